// ===== design/cpe_pkg.sv =====
// Shared types, constants and helper functions for the CIDR prefix exclusion block.
`default_nettype none

package cpe_pkg;

    localparam int ADDR_BITS = 32;
    localparam int LEN_W     = 6;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int IN_FIELD_BITS  = 2 * (ADDR_BITS + LEN_W);
    localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ADDR_BITS + LEN_W;
    localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_BITS);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [LEN_W-1:0]     len_t;

    // Which result the output register takes.
    typedef enum logic [1:0] {
        KIND_SOURCE,
        KIND_EMPTY,
        KIND_SIBLING
    } result_kind_t;

    typedef struct packed {
        logic         load;
        logic         emit;
        logic         step;
        result_kind_t kind;
    } cpe_cmd_t;

    typedef struct packed {
        logic disjoint;
        logic covered;
        logic final_level;
    } cpe_status_t;

    // Lengths above the address width saturate to a host prefix.
    function automatic len_t sat_len(input len_t len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // Network mask for a length of 0 up to the address width.
    function automatic addr_t net_mask(input len_t len);
        return ~({ADDR_BITS{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

// ===== design/cidr_prefix_exclusion.sv =====
// An accepted pair is loaded into the prefix registers and classified, and the first
// result then enters the single output register that the sibling walk feeds; that
// register takes a new result only when it is empty or being drained.
// A result waiting on m_tready stalls the walk; the next input is taken once
// the last result of the current one is in the output register.
// Reset (rst_n, asynchronous): controller idle, no result pending.
`default_nettype none

module cidr_prefix_exclusion (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // source_address[31:0], source_length[37:32], exclude_address[69:38],
    // exclude_length[75:70], zero pad above.
    input  wire  [cpe_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // result_address[31:0], result_length[37:32], zero pad above.
    output logic [cpe_pkg::OUT_DATA_W-1:0]    m_tdata,
    // empty_set[0].
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast
);
    import cpe_pkg::*;

    cpe_cmd_t    cmd;
    cpe_status_t status;
    addr_t       source_address;
    len_t        source_length;
    addr_t       exclude_address;
    len_t        exclude_length;
    addr_t       result_address;
    len_t        result_length;
    logic        empty_set;
    logic        last_result;

    assign source_address  = s_tdata[ADDR_BITS-1:0];
    assign source_length   = s_tdata[ADDR_BITS+LEN_W-1:ADDR_BITS];
    assign exclude_address = s_tdata[2*ADDR_BITS+LEN_W-1:ADDR_BITS+LEN_W];
    assign exclude_length  = s_tdata[IN_FIELD_BITS-1:2*ADDR_BITS+LEN_W];

    cpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    cpe_datapath u_datapath (
        .clk             (clk),
        .source_address  (source_address),
        .source_length   (source_length),
        .exclude_address (exclude_address),
        .exclude_length  (exclude_length),
        .cmd             (cmd),
        .status          (status),
        .result_address  (result_address),
        .result_length   (result_length),
        .empty_set       (empty_set),
        .last_result     (last_result)
    );

    assign m_tdata = OUT_DATA_W'({result_length, result_address});
    assign m_tuser = empty_set;
    assign m_tlast = last_result;

endmodule

`default_nettype wire

// ===== design/cpe_datapath.sv =====
// Datapath: holds the prefix pair, classifies it and forms each result prefix.
`default_nettype none

module cpe_datapath (
    input  wire                  clk,
    input  cpe_pkg::addr_t       source_address,
    input  cpe_pkg::len_t        source_length,
    input  cpe_pkg::addr_t       exclude_address,
    input  cpe_pkg::len_t        exclude_length,
    input  cpe_pkg::cpe_cmd_t    cmd,
    output cpe_pkg::cpe_status_t status,
    output cpe_pkg::addr_t       result_address,
    output cpe_pkg::len_t        result_length,
    output logic                 empty_set,
    output logic                 last_result
);
    import cpe_pkg::*;

    addr_t s_reg;
    len_t  sl_reg;
    addr_t e_reg;
    len_t  el_reg;
    len_t  k_reg;

    addr_t out_addr_reg;
    addr_t out_addr_next;
    len_t  out_len_reg;
    len_t  out_len_next;
    logic  out_empty_reg;
    logic  out_empty_next;
    logic  out_last_reg;
    logic  out_last_next;

    len_t  sl_sat;
    len_t  el_sat;
    len_t  common_len;
    addr_t common_mask;
    addr_t sibling_addr;

    assign sl_sat = sat_len(source_length);
    assign el_sat = sat_len(exclude_length);

    assign common_len  = (sl_reg < el_reg) ? sl_reg : el_reg;
    assign common_mask = net_mask(common_len);

    assign status.disjoint    = (s_reg & common_mask) != (e_reg & common_mask);
    assign status.covered     = (el_reg <= sl_reg);
    assign status.final_level = (k_reg == el_reg);

    // The half at level k that does not hold the exclude: flip the bit just
    // below the first k-1 bits of the exclude network.
    assign sibling_addr = (e_reg & net_mask(k_reg))
                        ^ ({1'b1, {(ADDR_BITS-1){1'b0}}} >> (k_reg - len_t'(1)));

    always_comb
    begin
        out_addr_next  = out_addr_reg;
        out_len_next   = out_len_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit)
        begin
            unique case (cmd.kind)
                KIND_SOURCE:
                begin
                    out_addr_next  = s_reg;
                    out_len_next   = sl_reg;
                    out_empty_next = 1'b0;
                    out_last_next  = 1'b1;
                end
                KIND_EMPTY:
                begin
                    out_addr_next  = '0;
                    out_len_next   = '0;
                    out_empty_next = 1'b1;
                    out_last_next  = 1'b1;
                end
                KIND_SIBLING:
                begin
                    out_addr_next  = sibling_addr;
                    out_len_next   = k_reg;
                    out_empty_next = 1'b0;
                    out_last_next  = status.final_level;
                end
                default:
                begin
                    out_addr_next  = out_addr_reg;
                    out_len_next   = out_len_reg;
                    out_empty_next = out_empty_reg;
                    out_last_next  = out_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg  <= source_address & net_mask(sl_sat);
            sl_reg <= sl_sat;
            e_reg  <= exclude_address & net_mask(el_sat);
            el_reg <= el_sat;
            k_reg  <= sl_sat + len_t'(1);
        end
        else if (cmd.step)
        begin
            k_reg <= k_reg + len_t'(1);
        end
        out_addr_reg  <= out_addr_next;
        out_len_reg   <= out_len_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign result_address = out_addr_reg;
    assign result_length  = out_len_reg;
    assign empty_set      = out_empty_reg;
    assign last_result    = out_last_reg;

endmodule

`default_nettype wire

// ===== design/cpe_ctrl.sv =====
// Controller: accepts a prefix pair, then issues one result per free output slot.
`default_nettype none

module cpe_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  cpe_pkg::cpe_status_t status,
    output cpe_pkg::cpe_cmd_t    cmd
);
    import cpe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.emit       = 1'b0;
        cmd.step       = 1'b0;
        cmd.kind       = KIND_SIBLING;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    priority if (status.disjoint)
                    begin
                        cmd.kind   = KIND_SOURCE;
                        state_next = ST_IDLE;
                    end
                    else if (status.covered)
                    begin
                        cmd.kind   = KIND_EMPTY;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.kind   = KIND_SIBLING;
                        cmd.step   = 1'b1;
                        state_next = status.final_level ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = KIND_SIBLING;
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.final_level)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== tb/sv/cidr_prefix_exclusion_test.sv =====
// Self-checking testbench for the CIDR prefix exclusion block with directed and random pairs.
`timescale 1ns / 1ps

module cidr_prefix_exclusion_test;

    import cpe_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        addr_t src_addr;
        len_t  src_len;
        addr_t exc_addr;
        len_t  exc_len;
    } prefix_pair_t;

    typedef struct packed {
        addr_t addr;
        len_t  len;
        logic  empty;
        logic  last;
    } prefix_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    prefix_result_t expected_prefixes[$];
    int             mismatch_count = 0;
    int             stuck_cycles = 0;
    int             hold_left = 0;
    bit             no_idle = 0;

    cidr_prefix_exclusion i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic addr_t prefix_mask(input int unsigned len);
        if (len == 0)
            return '0;
        return {ADDR_BITS{1'b1}} << (ADDR_BITS - len);
    endfunction

    function automatic int unsigned clamp_len(input len_t len);
        return (len > ADDR_BITS) ? ADDR_BITS : int'(len);
    endfunction

    // Works out the prefixes left after removing the exclude from the source.
    function automatic void predict_remainder(input prefix_pair_t pair);
        int unsigned    sl;
        int unsigned    el;
        int unsigned    common;
        addr_t          s;
        addr_t          e;
        addr_t          cm;
        prefix_result_t r;
        sl = clamp_len(pair.src_len);
        el = clamp_len(pair.exc_len);
        s = pair.src_addr & prefix_mask(sl);
        e = pair.exc_addr & prefix_mask(el);
        common = (sl < el) ? sl : el;
        cm = prefix_mask(common);
        if ((s & cm) != (e & cm))
        begin
            r = '{addr: s, len: len_t'(sl), empty: 1'b0, last: 1'b1};
            expected_prefixes.push_back(r);
        end
        else if (el <= sl)
        begin
            r = '{addr: '0, len: '0, empty: 1'b1, last: 1'b1};
            expected_prefixes.push_back(r);
        end
        else
        begin
            for (int unsigned k = sl + 1; k <= el; k++)
            begin
                r.addr  = (e & prefix_mask(k)) ^ (addr_t'(1) << (ADDR_BITS - k));
                r.len   = len_t'(k);
                r.empty = 1'b0;
                r.last  = (k == el);
                expected_prefixes.push_back(r);
            end
        end
    endfunction

    function automatic prefix_pair_t random_pair();
        prefix_pair_t p;
        int unsigned  mode;
        int unsigned  sl;
        int unsigned  el;
        mode = $urandom_range(0, 99);
        p.src_addr = $urandom;
        p.exc_addr = $urandom;
        if (mode < 50)
        begin
            // Exclude strictly inside the source: the sibling walk.
            sl = $urandom_range(0, 31);
            el = $urandom_range(sl + 1, 32);
            p.exc_addr = (p.src_addr & prefix_mask(sl)) | (p.exc_addr & ~prefix_mask(sl));
            p.src_len = len_t'(sl);
            p.exc_len = len_t'(el);
        end
        else if (mode < 65)
        begin
            el = $urandom_range(0, 32);
            sl = $urandom_range(el, 32);
            p.exc_addr = (p.src_addr & prefix_mask(el)) | (p.exc_addr & ~prefix_mask(el));
            p.src_len = len_t'(sl);
            p.exc_len = len_t'(el);
        end
        else if (mode < 85)
        begin
            p.src_len = len_t'($urandom_range(0, 32));
            p.exc_len = len_t'($urandom_range(0, 32));
        end
        else
        begin
            p.src_len = len_t'($urandom_range(0, 63));
            p.exc_len = len_t'($urandom_range(0, 63));
        end
        return p;
    endfunction

    // Offers one pair, waits for the transaction, then may idle for a random gap.
    task automatic send_pair(input prefix_pair_t pair);
        int unsigned r;
        int unsigned gap;
        @(negedge clk);
        s_tdata  <= {{(IN_DATA_W - IN_FIELD_BITS){1'b0}},
                     pair.exc_len, pair.exc_addr, pair.src_len, pair.src_addr};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_remainder(pair);
        gap = 0;
        if (!no_idle)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_fields(input addr_t sa, input len_t sl, input addr_t ea, input len_t el);
        prefix_pair_t p;
        p = '{src_addr: sa, src_len: sl, exc_addr: ea, exc_len: el};
        send_pair(p);
    endtask

    task automatic test_directed();
        send_fields(32'h0A00_0000, 6'd8,  32'hC0A8_0000, 6'd16);   // disjoint
        send_fields(32'h0A00_0000, 6'd8,  32'h0A01_0200, 6'd24);   // exclude inside
        send_fields(32'h0A01_0000, 6'd16, 32'h0A00_0000, 6'd8);    // exclude covers source
        send_fields(32'h0A00_0000, 6'd8,  32'h0A00_0000, 6'd8);    // equal prefixes
        send_fields(32'h0102_0304, 6'd32, 32'h0102_0305, 6'd32);   // host source, disjoint
        send_fields(32'h0102_0304, 6'd32, 32'h0102_0000, 6'd16);   // host source, covered
        send_fields(32'h0102_0304, 6'd32, 32'h0102_0304, 6'd32);
        send_fields(32'h0000_0000, 6'd0,  32'hFFFF_FFFF, 6'd32);   // longest walk
        send_fields(32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 6'd32);
        send_fields(32'h1234_5678, 6'd16, 32'h0000_0000, 6'd0);    // exclude everything
        send_fields(32'h0000_0000, 6'd0,  32'h0000_0000, 6'd0);
        send_fields(32'h0AFF_FFFF, 6'd8,  32'h0A01_02FF, 6'd24);   // host bits set
        send_fields(32'h8000_0000, 6'd1,  32'hC000_0000, 6'd2);    // one level deeper
        send_fields(32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63);   // lengths saturate
        send_fields(32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 6'd40);
        send_fields(32'hAAAA_AAAA, 6'd0,  32'h5555_5555, 6'd33);
        send_fields(32'h5555_5555, 6'd31, 32'h5555_5554, 6'd32);
        send_fields(32'h0000_0000, 6'd32, 32'hFFFF_FFFF, 6'd0);
        send_fields(32'hC0A8_0100, 6'd24, 32'hC0A8_0180, 6'd25);
        send_fields(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFE, 6'd32);
    endtask

    task automatic test_back_to_back();
        no_idle = 1;
        for (int i = 0; i < 30; i++)
            send_pair(random_pair());
        no_idle = 0;
    endtask

    // The receiver holds off for a long stretch while pairs keep coming.
    task automatic test_backpressure();
        no_idle = 1;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
        no_idle = 0;
    endtask

    task automatic test_random();
        for (int i = 0; i < 300; i++)
            send_pair(random_pair());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_back_to_back();
        test_backpressure();
        test_random();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_prefixes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result receiver: random stalls, always ready while no_idle is set, plus the long hold-off on request.
    initial
    begin
        int unsigned r;
        int          stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready <= 1'b1;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        prefix_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_prefixes.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h len=%0d empty=%b last=%b", $time,
                         m_tdata[31:0], m_tdata[37:32], m_tuser[0], m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_prefixes.pop_front();
                if (m_tdata[31:0] !== want.addr)
                begin
                    $display("%0t: result_address expected %h actual %h", $time,
                             want.addr, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[37:32] !== want.len)
                begin
                    $display("%0t: result_length expected %0d actual %0d", $time,
                             want.len, m_tdata[37:32]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.empty)
                begin
                    $display("%0t: empty_set expected %b actual %b", $time,
                             want.empty, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[OUT_DATA_W-1:OUT_FIELD_BITS] !== '0)
                begin
                    $display("%0t: tdata pad expected 0 actual %b", $time,
                             m_tdata[OUT_DATA_W-1:OUT_FIELD_BITS]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction happens on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: timeout, %0d results still expected", $time,
                         expected_prefixes.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
